FILE: hw/rtl/fbls_pkg.sv
// ----------------------------------------------------------------------------
// fbls_pkg: shared constants and helpers for the log power smoother
// Widths of the bin and result words, dB constants in Q8.8, and the
// elaboration-time Q16 log2 used to fold the transform size into an offset.
// ----------------------------------------------------------------------------
package fbls_pkg;

    localparam int FFT_POINTS_DEF = 512;

    localparam int IDX_W   = 9;   // bin index / display bin width
    localparam int MAG_W   = 24;  // signed component width
    localparam int POW_W   = 48;  // re^2 + im^2
    localparam int EXP_W   = 6;   // leading one position of the power
    localparam int MANT_W  = 31;  // Q1.30 mantissa
    localparam int FRAC_W  = 16;  // log2 fraction bits
    localparam int DB_W    = 16;  // Q8.8 dB

    localparam logic signed [DB_W-1:0] DB_FLOOR = -16'sd25600;  // -100 dB
    localparam logic signed [DB_W-1:0] DB_RESET = -16'sd17920;  // -70 dB
    localparam logic [DB_W-1:0]        DB_OFFSET = 16'd25600;   // +100 dB

    localparam int TEN_LOG10_2_Q16 = 197283;

    // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for x below 2^26
    localparam int RECIP_1000  = 68719477;
    localparam int RECIP_SHIFT = 36;

    // Q16 log2 of a positive constant, same rounding as the datapath
    function automatic logic [31:0] log2q_const(input int unsigned v);
        int unsigned e;
        logic [63:0] m;
        logic [15:0] frac;
        e    = 0;
        frac = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                e = i;
            end
        end
        m = 64'(v) << (30 - e);
        for (int i = 0; i < 16; i++) begin
            m    = (m * m) >> 30;
            frac = {frac[14:0], m[31]};
            if (m[31]) begin
                m = m >> 1;
            end
        end
        return {e[15:0], frac};
    endfunction

endpackage

FILE: hw/rtl/fbls_ram.sv
// ----------------------------------------------------------------------------
// fbls_ram: generic simple dual port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module fbls_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // write, and read the old contents
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/fbls_front.sv
// ----------------------------------------------------------------------------
// fbls_front: bin shift, power and normalization
// Six stages: index wrap and magnitudes, squares, sum, per-segment leading
// one, exponent select, mantissa shift to Q1.30.
// ----------------------------------------------------------------------------
module fbls_front #(
    parameter int FFT_POINTS = fbls_pkg::FFT_POINTS_DEF,
    parameter int POS_W      = $clog2(FFT_POINTS)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [fbls_pkg::IDX_W-1:0]          bin_index,
    input  logic signed [fbls_pkg::MAG_W-1:0]   bin_real,
    input  logic signed [fbls_pkg::MAG_W-1:0]   bin_imag,
    output logic                                out_valid,
    output logic [POS_W-1:0]                    out_pos,
    output logic [fbls_pkg::EXP_W-1:0]          out_exp,
    output logic [fbls_pkg::MANT_W-1:0]         out_mant,
    output logic                                out_zero
);

    localparam int IDX_W  = fbls_pkg::IDX_W;
    localparam int MAG_W  = fbls_pkg::MAG_W;
    localparam int POW_W  = fbls_pkg::POW_W;
    localparam int EXP_W  = fbls_pkg::EXP_W;
    localparam int MANT_W = fbls_pkg::MANT_W;
    localparam int HALF   = FFT_POINTS / 2;

    logic [5:0]            v_reg;
    logic [POS_W-1:0]      pos_reg [0:5];

    logic [IDX_W-1:0]      rem;
    logic [POS_W:0]        psum;
    logic [POS_W-1:0]      pos_next;
    logic [MAG_W-1:0]      mr_next, mi_next;
    logic [MAG_W-1:0]      mr_reg, mi_reg;
    logic [POW_W-1:0]      sqr_reg, sqi_reg;
    logic [POW_W-1:0]      p3_reg, p4_reg, p5_reg;
    logic [2:0]            nz_next, nz_reg;
    logic [3:0]            hp_next [0:2];
    logic [3:0]            hp_reg  [0:2];
    logic [EXP_W-1:0]      e_next, e5_reg, e6_reg;
    logic                  z5_reg, z6_reg;
    logic [POW_W-1:0]      sh;
    logic [MANT_W-1:0]     m6_reg;

    // wrap the index modulo the size, then rotate by half
    always_comb begin
        rem = bin_index;
        for (int j = IDX_W - 1; j >= 0; j--) begin
            if (32'(rem) >= (32'(FFT_POINTS) << j)) begin
                rem = rem - IDX_W'(32'(FFT_POINTS) << j);
            end
        end
        psum = (POS_W + 1)'(rem) + (POS_W + 1)'(HALF);
        if (psum >= (POS_W + 1)'(FFT_POINTS)) begin
            psum = psum - (POS_W + 1)'(FFT_POINTS);
        end
        pos_next = psum[POS_W-1:0];
    end

    // magnitudes; the most negative code maps to 2^23
    assign mr_next = bin_real[MAG_W-1] ? MAG_W'(-bin_real) : MAG_W'(bin_real);
    assign mi_next = bin_imag[MAG_W-1] ? MAG_W'(-bin_imag) : MAG_W'(bin_imag);

    // highest one inside each 16-bit segment of the power
    always_comb begin
        for (int s = 0; s < 3; s++) begin
            nz_next[s] = |p3_reg[s*16 +: 16];
            hp_next[s] = '0;
            for (int b = 0; b < 16; b++) begin
                if (p3_reg[s*16 + b]) begin
                    hp_next[s] = 4'(b);
                end
            end
        end
    end

    // pick the exponent from the top nonzero segment
    always_comb begin
        if (nz_reg[2]) begin
            e_next = {2'b10, hp_reg[2]};
        end else if (nz_reg[1]) begin
            e_next = {2'b01, hp_reg[1]};
        end else begin
            e_next = {2'b00, hp_reg[0]};
        end
    end

    // align the leading one to bit 30, truncating
    always_comb begin
        if (e5_reg >= EXP_W'(30)) begin
            sh = p5_reg >> (e5_reg - EXP_W'(30));
        end else begin
            sh = p5_reg << (EXP_W'(30) - e5_reg);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // datapath; advance with the pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            pos_reg[0] <= pos_next;
            for (int i = 1; i < 6; i++) begin
                pos_reg[i] <= pos_reg[i-1];
            end
            mr_reg  <= mr_next;
            mi_reg  <= mi_next;
            sqr_reg <= mr_reg * mr_reg;
            sqi_reg <= mi_reg * mi_reg;
            p3_reg  <= sqr_reg + sqi_reg;
            p4_reg  <= p3_reg;
            nz_reg  <= nz_next;
            hp_reg  <= hp_next;
            p5_reg  <= p4_reg;
            e5_reg  <= e_next;
            z5_reg  <= ~|nz_reg;
            e6_reg  <= e5_reg;
            z6_reg  <= z5_reg;
            m6_reg  <= sh[MANT_W-1:0];
        end
    end

    assign out_valid = v_reg[5];
    assign out_pos   = pos_reg[5];
    assign out_exp   = e6_reg;
    assign out_mant  = m6_reg;
    assign out_zero  = z6_reg;

endmodule

FILE: hw/rtl/fbls_log.sv
// ----------------------------------------------------------------------------
// fbls_log: log2 fraction and dB conversion
// Sixteen squaring stages yield one log2 fraction bit each; then the offset
// subtract with the dB scale multiply, and the round and clamp to Q8.8.
// ----------------------------------------------------------------------------
module fbls_log #(
    parameter int FFT_POINTS = fbls_pkg::FFT_POINTS_DEF,
    parameter int POS_W      = $clog2(FFT_POINTS)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [POS_W-1:0]                    in_pos,
    input  logic [fbls_pkg::EXP_W-1:0]          in_exp,
    input  logic [fbls_pkg::MANT_W-1:0]         in_mant,
    input  logic                                in_zero,
    output logic                                out_valid,
    output logic [POS_W-1:0]                    out_pos,
    output logic signed [fbls_pkg::DB_W-1:0]    out_db
);

    localparam int EXP_W  = fbls_pkg::EXP_W;
    localparam int MANT_W = fbls_pkg::MANT_W;
    localparam int FRAC_W = fbls_pkg::FRAC_W;
    localparam int DB_W   = fbls_pkg::DB_W;
    localparam int NSQ    = FRAC_W;
    localparam int DEN    = 14 * 65536 + 2 * int'(fbls_pkg::log2q_const(FFT_POINTS));
    localparam logic signed [18:0] K_DB = 19'(fbls_pkg::TEN_LOG10_2_Q16);
    localparam logic signed [42:0] DQ_FLOOR = -43'sd429496729600;

    logic                  v_reg    [1:NSQ];
    logic [POS_W-1:0]      pos_reg  [1:NSQ];
    logic [EXP_W-1:0]      e_reg    [1:NSQ];
    logic                  z_reg    [1:NSQ];
    logic [MANT_W-1:0]     m_reg    [1:NSQ];
    logic [FRAC_W-1:0]     f_reg    [1:NSQ];

    logic [MANT_W-1:0]     m_next   [0:NSQ-1];
    logic                  fb_next  [0:NSQ-1];

    logic                  va_reg, vb_reg;
    logic [POS_W-1:0]      posa_reg, posb_reg;
    logic                  za_reg;
    logic signed [23:0]    lval;
    logic signed [42:0]    dq_next, dq_reg;
    logic signed [42:0]    dq_rnd;
    logic signed [19:0]    r;
    logic signed [DB_W-1:0] db_next, db_reg;

    // one squaring per stage, one fraction bit per stage; stage zero is the input
    always_comb begin
        logic [61:0]       sq;
        logic [31:0]       t;
        logic [MANT_W-1:0] cur;
        cur = in_mant;
        for (int i = 0; i < NSQ; i++) begin
            sq         = cur * cur;
            t          = sq[61:30];
            m_next[i]  = t[31] ? t[31:1] : t[30:0];
            fb_next[i] = t[31];
            cur        = m_reg[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= NSQ; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[1] <= in_valid;
            for (int i = 1; i < NSQ; i++) begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos_reg[1] <= in_pos;
            e_reg[1]   <= in_exp;
            z_reg[1]   <= in_zero;
            m_reg[1]   <= m_next[0];
            f_reg[1]   <= FRAC_W'(fb_next[0]);
            for (int i = 1; i < NSQ; i++) begin
                pos_reg[i+1] <= pos_reg[i];
                e_reg[i+1]   <= e_reg[i];
                z_reg[i+1]   <= z_reg[i];
                m_reg[i+1]   <= m_next[i];
                f_reg[i+1]   <= {f_reg[i][FRAC_W-2:0], fb_next[i]};
            end
        end
    end

    // remove the scale offset and convert to dB in Q32
    assign lval    = $signed({2'b00, e_reg[NSQ], f_reg[NSQ]}) - $signed(24'(DEN));
    assign dq_next = lval * K_DB;

    // round to Q8.8, clamp at -100 dB and saturate at the top of the range
    always_comb begin
        dq_rnd = dq_reg + 43'sd8388608;
        r      = $signed(dq_rnd[42:24]);
        if (za_reg || (dq_reg < DQ_FLOOR)) begin
            db_next = fbls_pkg::DB_FLOOR;
        end else if (r < 20'(fbls_pkg::DB_FLOOR)) begin
            db_next = fbls_pkg::DB_FLOOR;
        end else if (r > 20'sd32767) begin
            db_next = 16'sd32767;
        end else begin
            db_next = r[DB_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (adv) begin
            va_reg <= v_reg[NSQ];
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            posa_reg <= pos_reg[NSQ];
            za_reg   <= z_reg[NSQ];
            dq_reg   <= dq_next;
            posb_reg <= posa_reg;
            db_reg   <= db_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_pos   = posb_reg;
    assign out_db    = db_reg;

endmodule

FILE: hw/rtl/fbls_avg.sv
// ----------------------------------------------------------------------------
// fbls_avg: per-bin exponential averaging
// Gain from the dB level, read of the stored level with forwarding of the
// last write, combinational update and write back, output register. Clears
// the level store to -70 dB after reset.
// ----------------------------------------------------------------------------
module fbls_avg #(
    parameter int FFT_POINTS = fbls_pkg::FFT_POINTS_DEF,
    parameter int POS_W      = $clog2(FFT_POINTS)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [POS_W-1:0]                    in_pos,
    input  logic signed [fbls_pkg::DB_W-1:0]    in_db,
    output logic                                busy,
    output logic                                out_valid,
    output logic [fbls_pkg::IDX_W-1:0]          out_bin,
    output logic signed [fbls_pkg::DB_W-1:0]    out_db
);

    localparam int DB_W  = fbls_pkg::DB_W;
    localparam int IDX_W = fbls_pkg::IDX_W;
    localparam int RSH   = fbls_pkg::RECIP_SHIFT;
    localparam logic [26:0] RECIP = 27'(fbls_pkg::RECIP_1000);
    localparam logic [POS_W-1:0] LAST = POS_W'(FFT_POINTS - 1);

    logic                   v1_reg, v2_reg, v3_reg;
    logic [POS_W-1:0]       pos1_reg, pos2_reg, pos3_reg;
    logic signed [DB_W-1:0] db1_reg, db2_reg, db3_reg;
    logic [DB_W-1:0]        d;
    logic [25:0]            x_next, x_reg;
    logic [52:0]            prod_reg;
    logic [DB_W-1:0]        g3_reg;

    logic                   clearing_reg;
    logic [POS_W-1:0]       clr_cnt_reg;

    logic [DB_W-1:0]        rdata;
    logic signed [DB_W-1:0] s;
    logic signed [16:0]     diff;
    logic signed [33:0]     prod2, rnd;
    logic signed [17:0]     delta;
    logic signed [18:0]     ns_wide;
    logic signed [DB_W-1:0] ns;

    logic                   fwd_v_reg;
    logic [POS_W-1:0]       fwd_pos_reg;
    logic signed [DB_W-1:0] fwd_db_reg;

    logic                   we;
    logic [POS_W-1:0]       waddr;
    logic [DB_W-1:0]        wdata;

    logic                   out_v_reg;
    logic [IDX_W-1:0]       out_bin_reg;
    logic signed [DB_W-1:0] out_db_reg;
    logic [31:0]            pos_ext;

    // numerator of the gain: (dB + 100 dB) * 768 + 500
    assign d      = DB_W'(in_db) + fbls_pkg::DB_OFFSET;
    assign x_next = (26'(d) << 9) + (26'(d) << 8) + 26'd500;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // divide by 1000 through the reciprocal
    always_ff @(posedge aclk) begin
        if (adv) begin
            pos1_reg <= in_pos;
            db1_reg  <= in_db;
            x_reg    <= x_next;
            pos2_reg <= pos1_reg;
            db2_reg  <= db1_reg;
            prod_reg <= 53'(x_reg) * 53'(RECIP);
            pos3_reg <= pos2_reg;
            db3_reg  <= db2_reg;
            g3_reg   <= prod_reg[RSH + DB_W - 1:RSH];
        end
    end

    // level store, read one stage ahead of the update
    fbls_ram #(
        .WIDTH (DB_W),
        .DEPTH (FFT_POINTS),
        .ADDR_W(POS_W)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (adv),
        .raddr(pos2_reg),
        .rdata(rdata)
    );

    // take the level written in the same cycle as the read
    assign s = (fwd_v_reg && (fwd_pos_reg == pos3_reg)) ? fwd_db_reg : $signed(rdata);

    // s' = s + round(g * (dB - s) / 2^16), saturated
    always_comb begin
        diff    = $signed({db3_reg[DB_W-1], db3_reg}) - $signed({s[DB_W-1], s});
        prod2   = $signed({1'b0, g3_reg}) * diff;
        rnd     = prod2 + 34'sd32768;
        delta   = rnd[33:16];
        ns_wide = 19'(s) + 19'(delta);
        if (ns_wide > 19'sd32767) begin
            ns = 16'sd32767;
        end else if (ns_wide < -19'sd32768) begin
            ns = -16'sd32768;
        end else begin
            ns = ns_wide[DB_W-1:0];
        end
    end

    // write port: clearing pass or update
    always_comb begin
        if (clearing_reg) begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = fbls_pkg::DB_RESET;
        end else begin
            we    = adv && v3_reg;
            waddr = pos3_reg;
            wdata = ns;
        end
    end

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            if (clr_cnt_reg == LAST) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // forward register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            fwd_v_reg <= v3_reg;
            out_v_reg <= v3_reg;
        end
    end

    assign pos_ext = 32'(pos3_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            fwd_pos_reg <= pos3_reg;
            fwd_db_reg  <= ns;
            out_bin_reg <= pos_ext[IDX_W-1:0];
            out_db_reg  <= ns;
        end
    end

    assign busy      = clearing_reg;
    assign out_valid = out_v_reg;
    assign out_bin   = out_bin_reg;
    assign out_db    = out_db_reg;

    // no word may be in flight while the store is being cleared
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> (!v1_reg && !v2_reg && !v3_reg))
        else $error("word in flight during clearing pass");

    // the clearing pass ends only after the last entry
    a_clear_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> ($past(clr_cnt_reg) == LAST))
        else $error("clearing pass ended early");

    // gain never exceeds 0.768 of the span from -100 dB to the Q8.8 maximum
    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (g3_reg <= 16'd44826))
        else $error("gain out of range");

    // a stalled update leaves the forwarded level alone
    a_fwd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(adv) && !$past(clearing_reg) |-> $stable(fwd_db_reg))
        else $error("forward register changed during stall");

endmodule

FILE: hw/rtl/fft_bin_log_power_smoother.sv
// ----------------------------------------------------------------------------
// fft_bin_log_power_smoother: per-bin log power with exponential averaging
// Takes one complex FFT bin a cycle while s_ready is high, forms its power
// in dBFS (Q8.8, floor at -100 dB), moves it to its DC-centered position
// and returns the updated smoothed level of that position.
//
//   channel   direction  handshake           word
//   s_        in         s_valid / s_ready   bin_index, bin_real, bin_imag
//   m_        out        m_valid / m_ready   display_bin, smoothed_db
//
// One word per cycle sustained while m_ready stays high, through the sixteen
// log2 squaring stages and the multiplies to the output register. After reset
// all FFT_POINTS entries (512 by default) of the level store are cleared;
// s_ready stays low during that pass. A low m_ready while m_valid is high
// holds the whole pipeline in place; nothing is lost.
// ----------------------------------------------------------------------------
module fft_bin_log_power_smoother #(
    parameter int FFT_POINTS = fbls_pkg::FFT_POINTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fbls_pkg::IDX_W-1:0]          s_bin_index,
    input  logic signed [fbls_pkg::MAG_W-1:0]   s_bin_real,
    input  logic signed [fbls_pkg::MAG_W-1:0]   s_bin_imag,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fbls_pkg::IDX_W-1:0]          m_display_bin,
    output logic signed [fbls_pkg::DB_W-1:0]    m_smoothed_db
);

    localparam int POS_W = $clog2(FFT_POINTS);

    logic                               adv;
    logic                               busy;
    logic                               f_valid;
    logic [POS_W-1:0]                   f_pos;
    logic [fbls_pkg::EXP_W-1:0]         f_exp;
    logic [fbls_pkg::MANT_W-1:0]        f_mant;
    logic                               f_zero;
    logic                               l_valid;
    logic [POS_W-1:0]                   l_pos;
    logic signed [fbls_pkg::DB_W-1:0]   l_db;

    // advance whenever the output register is free or being drained
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv && !busy;

    fbls_front #(
        .FFT_POINTS(FFT_POINTS),
        .POS_W     (POS_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid && s_ready),
        .bin_index(s_bin_index),
        .bin_real (s_bin_real),
        .bin_imag (s_bin_imag),
        .out_valid(f_valid),
        .out_pos  (f_pos),
        .out_exp  (f_exp),
        .out_mant (f_mant),
        .out_zero (f_zero)
    );

    fbls_log #(
        .FFT_POINTS(FFT_POINTS),
        .POS_W     (POS_W)
    ) u_log (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (f_valid),
        .in_pos   (f_pos),
        .in_exp   (f_exp),
        .in_mant  (f_mant),
        .in_zero  (f_zero),
        .out_valid(l_valid),
        .out_pos  (l_pos),
        .out_db   (l_db)
    );

    fbls_avg #(
        .FFT_POINTS(FFT_POINTS),
        .POS_W     (POS_W)
    ) u_avg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (l_valid),
        .in_pos   (l_pos),
        .in_db    (l_db),
        .busy     (busy),
        .out_valid(m_valid),
        .out_bin  (m_display_bin),
        .out_db   (m_smoothed_db)
    );

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fft_bin_log_power_smoother
// Drives complex bins through a valid/ready channel with random idle and
// stall bursts, predicts the shifted bin and smoothed dB level of every word,
// and compares each output word with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    import fbls_pkg::*;

    localparam int NPTS = FFT_POINTS_DEF;

    typedef struct packed {
        logic [IDX_W-1:0]        display_bin;
        logic signed [DB_W-1:0]  level;
    } level_word_t;

    // Track the per-bin smoothed levels and the words still to come out
    class level_scoreboard;
        logic signed [DB_W-1:0] levels [NPTS];
        level_word_t            pending [$];
        int                     checked;

        function new();
            foreach (levels[i]) levels[i] = DB_RESET;
            checked = 0;
        endfunction

        // Q16 log2: leading one, then sixteen squaring steps
        function automatic longint log2_q16(longint unsigned v);
            int               e;
            longint unsigned  m;
            longint           frac;
            e    = 63;
            frac = 0;
            if (v == 0) return 0;
            while (v[e] == 1'b0) e--;
            if (e <= 30) m = v << (30 - e);
            else         m = v >> (e - 30);
            for (int i = 0; i < 16; i++) begin
                m    = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    frac = frac | 1;
                    m    = m >> 1;
                end
            end
            return (longint'(e) << 16) | frac;
        endfunction

        // Predict the level update for one accepted bin
        function void note_bin(logic [IDX_W-1:0] idx, logic signed [MAG_W-1:0] re,
                               logic signed [MAG_W-1:0] im);
            int          pos;
            longint      a, b, p, den, l, dq, r, db, s, d, g, ns;
            level_word_t w;
            pos = ((int'(idx) % NPTS) + NPTS / 2) % NPTS;
            a   = re;
            b   = im;
            p   = a * a + b * b;
            if (p == 0) begin
                db = DB_FLOOR;
            end else begin
                den = 14 * 65536 + 2 * log2_q16(NPTS);
                l   = log2_q16(p) - den;
                dq  = l * TEN_LOG10_2_Q16;
                if (dq < -(longint'(100) <<< 32)) begin
                    db = DB_FLOOR;
                end else begin
                    r = ((dq + (longint'(128) <<< 32) + (longint'(1) <<< 23)) >>> 24)
                        - 32768;
                    if (r < DB_FLOOR) r = DB_FLOOR;
                    if (r > 32767) r = 32767;
                    db = r;
                end
            end
            s  = levels[pos];
            d  = db + 25600;
            g  = (d * 768 + 500) / 1000;
            ns = s + ((g * (db - s) + 32768) >>> 16);
            if (ns > 32767) ns = 32767;
            if (ns < -32768) ns = -32768;
            levels[pos]   = DB_W'(ns);
            w.display_bin = IDX_W'(pos);
            w.level       = DB_W'(ns);
            pending.push_back(w);
        endfunction

        // Compare one output word with the oldest prediction
        function bit check_word(logic [IDX_W-1:0] bin, logic signed [DB_W-1:0] lvl,
                                output string msg);
            level_word_t w;
            checked++;
            if (pending.size() == 0) begin
                msg = $sformatf("unexpected word bin=%0d level=%0d", bin, lvl);
                return 0;
            end
            w = pending.pop_front();
            if (bin !== w.display_bin || lvl !== w.level) begin
                msg = $sformatf("word %0d: bin=%0d level=%0d, predicted bin=%0d level=%0d",
                                checked, bin, lvl, w.display_bin, w.level);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [IDX_W-1:0]         s_bin_index;
    logic signed [MAG_W-1:0]  s_bin_real;
    logic signed [MAG_W-1:0]  s_bin_imag;
    logic                     m_valid;
    logic                     m_ready;
    logic [IDX_W-1:0]         m_display_bin;
    logic signed [DB_W-1:0]   m_smoothed_db;

    level_scoreboard sb;
    int              mismatches;
    int              bins_sent;
    bit              idle_on;

    fft_bin_log_power_smoother dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_bin_index   (s_bin_index),
        .s_bin_real    (s_bin_real),
        .s_bin_imag    (s_bin_imag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_display_bin (m_display_bin),
        .m_smoothed_db (m_smoothed_db)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Watch both channels at each edge
    always @(posedge aclk) begin
        string msg;
        if (aresetn && s_valid && s_ready) begin
            sb.note_bin(s_bin_index, s_bin_real, s_bin_imag);
        end
        if (aresetn && m_valid && m_ready) begin
            if (!sb.check_word(m_display_bin, m_smoothed_db, msg)) report(msg);
        end
    end

    // Stall the output in random bursts while idling is enabled
    initial begin
        m_ready = 1'b1;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Present one word and hold it until accepted
    task automatic send_bin(logic [IDX_W-1:0] idx, logic signed [MAG_W-1:0] re,
                            logic signed [MAG_W-1:0] im);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_bin_index <= idx;
        s_bin_real  <= re;
        s_bin_imag  <= im;
        do @(posedge aclk); while (!s_ready);
        bins_sent++;
    endtask

    // Component with a spread of magnitudes so dB covers its whole range
    function automatic logic signed [MAG_W-1:0] rand_part();
        logic signed [MAG_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = MAG_W'($urandom);
            1:       v = 0;
            default: v = MAG_W'($urandom_range(0, 8388607) >> $urandom_range(0, 23));
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    initial begin
        logic [IDX_W-1:0] hot;
        sb          = new();
        mismatches  = 0;
        bins_sent   = 0;
        idle_on     = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_bin_index = '0;
        s_bin_real  = '0;
        s_bin_imag  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes, zero power, floor region, index edges
        send_bin(0, 0, 0);
        send_bin(511, -24'sd8388608, -24'sd8388608);
        send_bin(511, -24'sd8388608, -24'sd8388608);
        send_bin(256, 24'sd8388607, 24'sd8388607);
        send_bin(255, 24'sd8388607, 0);
        send_bin(1, 1, 0);
        send_bin(2, 0, -1);
        send_bin(3, 24'sd200, 24'sd100);
        send_bin(3, 24'sd2000, -24'sd1000);
        send_bin(4, 24'sd65536, 0);
        send_bin(4, 0, 24'sd65536);
        send_bin(128, -24'sd1, 24'sd8388607);
        send_bin(384, 24'sd1 <<< 22, -24'sd1 <<< 22);
        send_bin(511, 0, 0);
        for (int i = 0; i < 6; i++) send_bin(7, 24'sd4194304, 24'sd4194304);

        // Random bins; repeated hot bins drive the averaging far from reset
        idle_on = 1'b1;
        hot     = IDX_W'($urandom);
        for (int i = 0; i < 700; i++) begin
            if (i % 150 == 100) idle_on = 1'b0;
            if (i % 150 == 0)   idle_on = 1'b1;
            if (i >= 620)       idle_on = 1'b0;
            if ($urandom_range(0, 2) == 0) begin
                if ($urandom_range(0, 15) == 0) hot = IDX_W'($urandom);
                send_bin(hot, rand_part(), rand_part());
            end else begin
                send_bin(IDX_W'($urandom), rand_part(), rand_part());
            end
        end
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Sent %0d bins, checked %0d output words, %0d mismatches.",
                 bins_sent, sb.checked, mismatches);
        if (mismatches == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/fbls_pkg.sv
hw/rtl/fbls_ram.sv
hw/rtl/fbls_front.sv
hw/rtl/fbls_log.sv
hw/rtl/fbls_avg.sv
hw/rtl/fft_bin_log_power_smoother.sv
verif/testbench.sv
